>>> design/ahrs_pkg.sv
// Shared constants for the attitude filter: datapath widths, register
// indexes and fixed-point constants. No dependencies.
package ahrs_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int RSQRT_STEPS_DEF = 3;

  // Shared multiplier operand and product widths, accumulator width.
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 72;

  // Width of the corrected angular rate before saturation.
  localparam int RATE_W = 40;

  // Configuration register indexes.
  localparam logic [1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [1:0] REG_PERIOD      = 2'd2;

  localparam logic [23:0] PROP_GAIN_RST  = 24'd65536;
  localparam logic [23:0] INTEG_GAIN_RST = 24'd0;
  localparam logic [31:0] PERIOD_RST     = 32'd8388608;

  localparam logic [31:0] SEED_MAGIC     = 32'h5f375a86;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

endpackage

>>> design/imu_attitude_complementary_filter.sv
// Attitude filter top level: one request at a time, all products through a
// single registered multiplier under a sequencer. How long a request takes
// depends on whether the acceleration is zero, the two normalize loops, the
// Newton steps and the integral gain. A new request is taken only after the
// result has been taken. Reset gives the identity quaternion, zero integral
// and default gains; the block is ready as soon as reset is released.
module imu_attitude_complementary_filter #(
  parameter int DATA_WIDTH  = ahrs_pkg::DATA_WIDTH_DEF,
  parameter int RSQRT_STEPS = ahrs_pkg::RSQRT_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] gyro_x,
  input  logic signed [31:0] gyro_y,
  input  logic signed [31:0] gyro_z,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               accel_used,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = ahrs_pkg::ACC_W;
  localparam int MW = ahrs_pkg::MUL_W;
  localparam int GW = ahrs_pkg::RATE_W;
  localparam int KW = $clog2(RSQRT_STEPS + 1);

  localparam logic signed [49:0] RLIM = (50'sd1 <<< (DATA_WIDTH - 1)) - 50'sd1;
  localparam logic signed [AW-1:0] LIM32 = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] LIM_HALF = AW'(64'sd268435456);
  localparam logic signed [AW-1:0] THREE_HALF = AW'(64'sd1610612736);
  localparam logic signed [AW-1:0] HALF_Q30 = AW'(64'sd536870912);
  localparam logic signed [AW-1:0] RANGE_HI = AW'(64'sd4294967296);
  localparam logic signed [AW-1:0] RANGE_LO = AW'(64'sd1073741824);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ASQ  = 5'd1;
  localparam logic [4:0] S_NORM = 5'd2;
  localparam logic [4:0] S_NT   = 5'd3;
  localparam logic [4:0] S_NH   = 5'd4;
  localparam logic [4:0] S_NY   = 5'd5;
  localparam logic [4:0] S_NA   = 5'd6;
  localparam logic [4:0] S_GV   = 5'd7;
  localparam logic [4:0] S_ER   = 5'd8;
  localparam logic [4:0] S_KI   = 5'd9;
  localparam logic [4:0] S_KIR  = 5'd10;
  localparam logic [4:0] S_KP   = 5'd11;
  localparam logic [4:0] S_SP   = 5'd12;
  localparam logic [4:0] S_HC   = 5'd13;
  localparam logic [4:0] S_HW   = 5'd14;
  localparam logic [4:0] S_QU   = 5'd15;
  localparam logic [4:0] S_QS   = 5'd16;
  localparam logic [4:0] S_QN   = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  function automatic logic signed [31:0] clamp32(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    begin
      if (v > LIM32) r = LIM32;
      else if (v < -LIM32) r = -LIM32;
      else r = v;
      clamp32 = r[31:0];
    end
  endfunction

  // Float-style seed for the reciprocal square root of m in [2^30, 2^32).
  function automatic logic [32:0] rsqrt_seed(input logic [31:0] m);
    logic [31:0] bits;
    logic [31:0] j;
    logic [7:0]  ye;
    logic [23:0] ym;
    begin
      if (!m[31]) bits = {1'b0, 8'd127, m[29:7]};
      else        bits = {1'b0, 8'd128, m[30:8]};
      j  = ahrs_pkg::SEED_MAGIC - {1'b0, bits[31:1]};
      ye = j[30:23];
      ym = {1'b1, j[22:0]};
      if (ye >= 8'd120 && ye <= 8'd126) rsqrt_seed = {9'd0, ym} << (ye - 8'd120);
      else rsqrt_seed = 33'd1 << 30;
    end
  endfunction

  logic [4:0]  state;
  logic        ph;
  logic [3:0]  idx;
  logic [1:0]  sj;
  logic [KW-1:0] k;
  logic        second;
  logic [4:0]  shift;

  logic [23:0] prop_gain;
  logic [23:0] integ_gain;
  logic [31:0] period;

  logic signed [31:0] q  [4];
  logic signed [31:0] ie [3];
  logic signed [31:0] a  [3];
  logic signed [31:0] n  [3];
  logic signed [31:0] v  [3];
  logic signed [31:0] e  [3];
  logic signed [31:0] h  [3];
  logic signed [31:0] qn [4];
  logic signed [GW-1:0] g [3];
  logic        used;

  logic [32:0] y;
  logic [32:0] m;
  logic [32:0] t;
  logic [32:0] f;
  logic signed [AW-1:0] acc;
  logic [47:0] sp_m;
  logic        sp_neg;
  logic        sp_int;
  logic signed [31:0] spv;

  logic signed [MW-1:0] ma;
  logic signed [MW-1:0] mb;
  logic signed [ahrs_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0] p;
  logic        mstate;

  logic [1:0]  qu_q;
  logic [1:0]  qu_h;
  logic [1:0]  qu_row;
  logic        qu_neg;
  logic        qu_first;
  logic        qu_last;

  logic signed [AW-1:0] fcalc;
  logic signed [AW-1:0] ki_x;
  logic signed [AW-1:0] ki_mag;
  logic signed [AW-1:0] sp_sum;
  logic signed [AW-1:0] sp_r;
  logic signed [AW-1:0] sp_c;
  logic signed [AW-1:0] sp_lim;
  logic signed [31:0]   ie_new;
  logic signed [49:0]   gc;
  logic signed [49:0]   gc_mag;
  logic signed [AW-1:0] qu_sum;

  ahrs_mul u_mul (
    .clk  (clk),
    .a    (ma),
    .b    (mb),
    .prod (prod)
  );

  assign p = AW'(prod);

  // Quaternion product table: row, source component, half-angle axis, sign.
  always_comb begin
    qu_row = 2'd0; qu_q = 2'd0; qu_h = 2'd0; qu_neg = 1'b0;
    case (idx)
      4'd0:  begin qu_row = 2'd0; qu_q = 2'd1; qu_h = 2'd0; qu_neg = 1'b1; end
      4'd1:  begin qu_row = 2'd0; qu_q = 2'd2; qu_h = 2'd1; qu_neg = 1'b1; end
      4'd2:  begin qu_row = 2'd0; qu_q = 2'd3; qu_h = 2'd2; qu_neg = 1'b1; end
      4'd3:  begin qu_row = 2'd1; qu_q = 2'd0; qu_h = 2'd0; qu_neg = 1'b0; end
      4'd4:  begin qu_row = 2'd1; qu_q = 2'd2; qu_h = 2'd2; qu_neg = 1'b0; end
      4'd5:  begin qu_row = 2'd1; qu_q = 2'd3; qu_h = 2'd1; qu_neg = 1'b1; end
      4'd6:  begin qu_row = 2'd2; qu_q = 2'd0; qu_h = 2'd1; qu_neg = 1'b0; end
      4'd7:  begin qu_row = 2'd2; qu_q = 2'd1; qu_h = 2'd2; qu_neg = 1'b1; end
      4'd8:  begin qu_row = 2'd2; qu_q = 2'd3; qu_h = 2'd0; qu_neg = 1'b0; end
      4'd9:  begin qu_row = 2'd3; qu_q = 2'd0; qu_h = 2'd2; qu_neg = 1'b0; end
      4'd10: begin qu_row = 2'd3; qu_q = 2'd1; qu_h = 2'd1; qu_neg = 1'b0; end
      4'd11: begin qu_row = 2'd3; qu_q = 2'd2; qu_h = 2'd0; qu_neg = 1'b1; end
      default: begin qu_row = 2'd0; qu_q = 2'd0; qu_h = 2'd0; qu_neg = 1'b0; end
    endcase
    qu_first = (idx == 4'd0) || (idx == 4'd3) || (idx == 4'd6) || (idx == 4'd9);
    qu_last  = (idx == 4'd2) || (idx == 4'd5) || (idx == 4'd8) || (idx == 4'd11);
  end

  // Multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    mstate = 1'b0;
    case (state)
      S_ASQ: begin ma = MW'(a[idx[1:0]]); mb = MW'(a[idx[1:0]]); mstate = 1'b1; end
      S_NT:  begin ma = MW'(y); mb = MW'(y); mstate = 1'b1; end
      S_NH:  begin ma = MW'(m); mb = MW'(t); mstate = 1'b1; end
      S_NY:  begin ma = MW'(y); mb = MW'(f); mstate = 1'b1; end
      S_NA:  begin ma = MW'(a[idx[1:0]]); mb = MW'(y); mstate = 1'b1; end
      S_GV: begin
        mstate = 1'b1;
        case (idx)
          4'd0: begin ma = MW'(q[1]); mb = MW'(q[3]); end
          4'd1: begin ma = MW'(q[0]); mb = MW'(q[2]); end
          4'd2: begin ma = MW'(q[0]); mb = MW'(q[1]); end
          4'd3: begin ma = MW'(q[2]); mb = MW'(q[3]); end
          4'd4: begin ma = MW'(q[0]); mb = MW'(q[0]); end
          default: begin ma = MW'(q[3]); mb = MW'(q[3]); end
        endcase
      end
      S_ER: begin
        mstate = 1'b1;
        case (idx)
          4'd0: begin ma = MW'(n[1]); mb = MW'(v[2]); end
          4'd1: begin ma = MW'(n[2]); mb = MW'(v[1]); end
          4'd2: begin ma = MW'(n[2]); mb = MW'(v[0]); end
          4'd3: begin ma = MW'(n[0]); mb = MW'(v[2]); end
          4'd4: begin ma = MW'(n[0]); mb = MW'(v[1]); end
          default: begin ma = MW'(n[1]); mb = MW'(v[0]); end
        endcase
      end
      S_KI: begin
        ma = MW'(integ_gain); mb = MW'(e[idx[1:0]]); mstate = (integ_gain != 24'd0);
      end
      S_KP: begin ma = MW'(prop_gain); mb = MW'(e[idx[1:0]]); mstate = 1'b1; end
      S_SP: begin
        mstate = 1'b1;
        case (sj)
          2'd0: begin ma = MW'(sp_m[47:24]); mb = MW'(period[15:0]); end
          2'd1: begin ma = MW'(sp_m[23:0]);  mb = MW'(period[15:0]); end
          2'd2: begin ma = MW'(sp_m[47:24]); mb = MW'(period[31:16]); end
          default: begin ma = MW'(sp_m[23:0]); mb = MW'(period[31:16]); end
        endcase
      end
      S_QU: begin ma = MW'(q[qu_q]); mb = MW'(h[qu_h]); mstate = 1'b1; end
      S_QS: begin ma = MW'(qn[idx[1:0]]); mb = MW'(qn[idx[1:0]]); mstate = 1'b1; end
      S_QN: begin ma = MW'(qn[idx[1:0]]); mb = MW'(y); mstate = 1'b1; end
      default: begin ma = '0; mb = '0; mstate = 1'b0; end
    endcase
  end

  always_comb begin
    fcalc  = THREE_HALF - (p >>> 31);
    ki_x   = p >>> 14;
    ki_mag = ki_x[AW-1] ? -ki_x : ki_x;
    sp_sum = acc + p;
    sp_r   = sp_int ? (sp_sum >>> 32) : (sp_sum >>> 3);
    sp_lim = sp_int ? LIM32 : LIM_HALF;
    sp_c   = (sp_r > sp_lim) ? sp_lim : sp_r;
    ie_new = clamp32(AW'(ie[idx[1:0]]) + AW'(spv));
    gc     = 50'(g[idx[1:0]]);
    if (gc > RLIM) gc = RLIM;
    else if (gc < -RLIM) gc = -RLIM;
    gc_mag = gc[49] ? -gc : gc;
    if (qu_first) qu_sum = qu_neg ? -p : p;
    else qu_sum = qu_neg ? (acc - p) : (acc + p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ph         <= 1'b0;
      idx        <= '0;
      sj         <= '0;
      k          <= '0;
      second     <= 1'b0;
      shift      <= 5'd15;
      used       <= 1'b0;
      prop_gain  <= ahrs_pkg::PROP_GAIN_RST;
      integ_gain <= ahrs_pkg::INTEG_GAIN_RST;
      period     <= ahrs_pkg::PERIOD_RST;
      q[0]       <= ahrs_pkg::ONE_Q30;
      q[1]       <= '0;
      q[2]       <= '0;
      q[3]       <= '0;
      ie[0]      <= '0;
      ie[1]      <= '0;
      ie[2]      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ahrs_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_data[23:0];
          ahrs_pkg::REG_INTEG_GAIN: integ_gain <= cfg_data[23:0];
          ahrs_pkg::REG_PERIOD:     period     <= cfg_data;
          default: ;
        endcase
      end
      if (mstate && !ph) begin
        ph <= 1'b1;
      end else begin
        ph <= 1'b0;
        case (state)
          S_IDLE: begin
            if (in_valid) begin
              a[0] <= accel_x;
              a[1] <= accel_y;
              a[2] <= accel_z;
              g[0] <= GW'(gyro_x);
              g[1] <= GW'(gyro_y);
              g[2] <= GW'(gyro_z);
              used <= (accel_x != 0) || (accel_y != 0) || (accel_z != 0);
              acc <= '0;
              idx <= '0;
              second <= 1'b0;
              shift <= 5'd15;
              if ((accel_x != 0) || (accel_y != 0) || (accel_z != 0)) state <= S_ASQ;
              else state <= S_HC;
            end
          end
          S_ASQ: begin
            acc <= acc + p;
            if (idx == 4'd2) begin
              idx <= '0;
              state <= S_NORM;
            end else begin
              idx <= idx + 4'd1;
            end
          end
          // Bring the sum of squares into [2^30, 2^32) two bits at a time.
          S_NORM: begin
            if (acc >= RANGE_HI) begin
              acc <= acc >>> 2;
              shift <= shift + 5'd1;
            end else if (acc < RANGE_LO) begin
              acc <= acc <<< 2;
              shift <= shift - 5'd1;
            end else begin
              m <= acc[32:0];
              y <= rsqrt_seed(acc[31:0]);
              k <= '0;
              state <= S_NT;
            end
          end
          S_NT: begin
            t <= p[62:30];
            state <= S_NH;
          end
          S_NH: begin
            f <= fcalc[AW-1] ? 33'd0 : fcalc[32:0];
            state <= S_NY;
          end
          S_NY: begin
            y <= p[62:30];
            if (k == KW'(RSQRT_STEPS - 1)) begin
              idx <= '0;
              state <= second ? S_QN : S_NA;
            end else begin
              k <= k + KW'(1);
              state <= S_NT;
            end
          end
          S_NA: begin
            n[idx[1:0]] <= clamp32(p >>> shift);
            if (idx == 4'd2) begin
              idx <= '0;
              state <= S_GV;
            end else begin
              idx <= idx + 4'd1;
            end
          end
          S_GV: begin
            if (!idx[0]) begin
              acc <= p;
            end else if (idx == 4'd1) begin
              v[0] <= clamp32((acc - p) >>> 30);
            end else if (idx == 4'd3) begin
              v[1] <= clamp32((acc + p) >>> 30);
            end else begin
              v[2] <= clamp32(((acc + p) >>> 30) - HALF_Q30);
            end
            if (idx == 4'd5) begin
              idx <= '0;
              state <= S_ER;
            end else begin
              idx <= idx + 4'd1;
            end
          end
          S_ER: begin
            if (!idx[0]) acc <= p;
            else e[idx[2:1]] <= clamp32((acc - p) >>> 30);
            if (idx == 4'd5) begin
              idx <= '0;
              state <= S_KI;
            end else begin
              idx <= idx + 4'd1;
            end
          end
          S_KI: begin
            if (integ_gain == 24'd0) begin
              ie[idx[1:0]] <= '0;
              state <= S_KP;
            end else begin
              sp_neg <= ki_x[AW-1];
              sp_m   <= ki_mag[47:0];
              sp_int <= 1'b1;
              sj     <= '0;
              state  <= S_SP;
            end
          end
          S_KIR: begin
            ie[idx[1:0]] <= ie_new;
            g[idx[1:0]]  <= g[idx[1:0]] + GW'(ie_new);
            state <= S_KP;
          end
          S_KP: begin
            g[idx[1:0]] <= g[idx[1:0]] + GW'(p >>> 30);
            if (idx == 4'd2) begin
              idx <= '0;
              state <= S_HC;
            end else begin
              idx <= idx + 4'd1;
              state <= S_KI;
            end
          end
          // Magnitude times period over four partial products.
          S_SP: begin
            sj <= sj + 2'd1;
            case (sj)
              2'd0: acc <= p <<< 24;
              2'd1: acc <= sp_sum >>> 16;
              2'd2: acc <= acc + (p <<< 24);
              default: begin
                spv   <= sp_neg ? -sp_c[31:0] : sp_c[31:0];
                state <= sp_int ? S_KIR : S_HW;
              end
            endcase
          end
          S_HC: begin
            sp_neg <= gc[49];
            sp_m   <= gc_mag[47:0];
            sp_int <= 1'b0;
            sj     <= '0;
            state  <= S_SP;
          end
          S_HW: begin
            h[idx[1:0]] <= spv;
            if (idx == 4'd2) begin
              idx <= '0;
              state <= S_QU;
            end else begin
              idx <= idx + 4'd1;
              state <= S_HC;
            end
          end
          S_QU: begin
            acc <= qu_sum;
            if (qu_last) qn[qu_row] <= clamp32(AW'(q[qu_row]) + (qu_sum >>> 30));
            if (idx == 4'd11) begin
              idx <= '0;
              state <= S_QS;
            end else begin
              idx <= idx + 4'd1;
            end
          end
          S_QS: begin
            if (idx == 4'd0) acc <= p;
            else acc <= acc + p;
            if (idx == 4'd3) begin
              idx <= '0;
              if (acc + p == '0) begin
                // A quaternion that collapsed to zero restarts from identity.
                q[0] <= ahrs_pkg::ONE_Q30;
                q[1] <= '0;
                q[2] <= '0;
                q[3] <= '0;
                state <= S_OUT;
              end else begin
                second <= 1'b1;
                shift  <= 5'd15;
                state  <= S_NORM;
              end
            end else begin
              idx <= idx + 4'd1;
            end
          end
          S_QN: begin
            q[idx[1:0]] <= clamp32(p >>> shift);
            if (idx == 4'd3) begin
              idx <= '0;
              state <= S_OUT;
            end else begin
              idx <= idx + 4'd1;
            end
          end
          S_OUT: begin
            if (out_ready) state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign in_ready   = (state == S_IDLE) && !rst;
  assign out_valid  = (state == S_OUT);
  assign cfg_ready  = !rst;
  assign quat_w     = q[0];
  assign quat_x     = q[1];
  assign quat_y     = q[2];
  assign quat_z     = q[3];
  assign accel_used = used;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready && !out_valid)
    else $error("sequencer did not start on an accepted request");

  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready)
    else $error("block not ready after result was taken");

  a_mul_phase: assert property (@(posedge clk) disable iff (rst)
    ph |-> $past(mstate) && (state == $past(state)))
    else $error("product phase outside a multiply step");

endmodule

>>> design/ahrs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ahrs_pkg for the operand width.
module ahrs_mul (
  input  logic                              clk,
  input  logic signed [ahrs_pkg::MUL_W-1:0]  a,
  input  logic signed [ahrs_pkg::MUL_W-1:0]  b,
  output logic signed [ahrs_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
